// File: rtl/lrmp_pkg.sv
// Shared constants, cell control types and modular arithmetic helpers
// for the step-sequence counter. No dependencies.
`default_nettype none

package lrmp_pkg;

    localparam int W         = 30;           // residue width
    localparam int MASK_W    = 15;           // step mask register width
    localparam int N_W       = 60;           // target count width
    localparam int ORDER_DEF = 15;
    localparam int IDX_W     = 5;            // holds a cell index for any order up to 32
    localparam int MUL_STEPS = W / 2;        // two multiplier bits per cycle

    localparam logic [W-1:0] P_MOD = 30'd1000000007;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_R_INIT,
        OP_LOAD_BCAST,
        OP_LOAD_OWN,
        OP_MUL,
        OP_STEP_SQ,
        OP_STEP_X,
        OP_PLACE,
        OP_SHIFT,
        OP_ACC_FROM_R,
        OP_R_FROM_ACC
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic             g_we;
        logic [IDX_W-1:0] g_idx;
        logic [W-1:0]     g_data;
        logic [W-1:0]     bcast;
    } cell_ctrl_t;

    function automatic logic [W-1:0] mod_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P_MOD}) s = s - {1'b0, P_MOD};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mod_add3(input logic [W-1:0] a, input logic [W-1:0] b,
                                              input logic [W-1:0] c);
        logic [W+1:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (s >= {2'b00, P_MOD}) s = s - {2'b00, P_MOD};
        if (s >= {2'b00, P_MOD}) s = s - {2'b00, P_MOD};
        return s[W-1:0];
    endfunction

    // one step of MSB-first interleaved modular multiply: 2*acc + bit*a mod p
    function automatic logic [W-1:0] mod_dbl_add(input logic [W-1:0] acc, input logic bit_i,
                                                 input logic [W-1:0] a);
        logic [W+1:0] s;
        s = {1'b0, acc, 1'b0} + (bit_i ? {2'b00, a} : {(W+2){1'b0}});
        if (s >= {2'b00, P_MOD}) s = s - {2'b00, P_MOD};
        if (s >= {2'b00, P_MOD}) s = s - {2'b00, P_MOD};
        return s[W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/lrmp_cell.sv
// One polynomial coefficient cell: holds r_k, table entry g_k, an accumulator
// and a 2-bit/cycle modular multiplier. Depends on lrmp_pkg.
`default_nettype none

module lrmp_cell #(
    parameter int INDEX = 0
) (
    input  wire                      aclk,
    input  wire  lrmp_pkg::cell_ctrl_t ctrl,
    input  wire  [lrmp_pkg::W-1:0]   left_acc,
    input  wire  [lrmp_pkg::W-1:0]   fb_val,
    input  wire                      fb_en,
    output logic [lrmp_pkg::W-1:0]   acc_o,
    output logic [lrmp_pkg::W-1:0]   r_o,
    output logic [lrmp_pkg::W-1:0]   g_o
);

    localparam int W = lrmp_pkg::W;

    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] g_reg, g_next;
    logic [W-1:0] ma_reg, ma_next;
    logic [W-1:0] mb_reg, mb_next;
    logic [W-1:0] mul_reg, mul_next;
    logic [W-1:0] fb_term;

    always_comb begin
        acc_next = acc_reg;
        r_next   = r_reg;
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        mul_next = mul_reg;
        g_next   = (ctrl.g_we && (ctrl.g_idx == lrmp_pkg::IDX_W'(INDEX))) ? ctrl.g_data : g_reg;
        fb_term  = fb_en ? fb_val : '0;
        unique case (ctrl.op)
            lrmp_pkg::OP_NOP: ;
            lrmp_pkg::OP_R_INIT: begin
                r_next   = W'(INDEX == 0);
                acc_next = '0;
            end
            lrmp_pkg::OP_LOAD_BCAST: begin
                ma_next  = r_reg;
                mb_next  = ctrl.bcast;
                mul_next = '0;
            end
            lrmp_pkg::OP_LOAD_OWN: begin
                ma_next  = g_reg;
                mb_next  = r_reg;
                mul_next = '0;
            end
            lrmp_pkg::OP_MUL: begin
                mul_next = lrmp_pkg::mod_dbl_add(
                               lrmp_pkg::mod_dbl_add(mul_reg, mb_reg[W-1], ma_reg),
                               mb_reg[W-2], ma_reg);
                mb_next  = {mb_reg[W-3:0], 2'b00};
            end
            // acc * x mod c(x) plus the product
            lrmp_pkg::OP_STEP_SQ:    acc_next = lrmp_pkg::mod_add3(left_acc, fb_term, mul_reg);
            lrmp_pkg::OP_STEP_X:     acc_next = lrmp_pkg::mod_add(left_acc, fb_term);
            lrmp_pkg::OP_PLACE:      acc_next = mul_reg;
            lrmp_pkg::OP_SHIFT:      acc_next = left_acc;
            lrmp_pkg::OP_ACC_FROM_R: acc_next = r_reg;
            lrmp_pkg::OP_R_FROM_ACC: begin
                r_next   = acc_reg;
                acc_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        r_reg   <= r_next;
        g_reg   <= g_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        mul_reg <= mul_next;
    end

    assign acc_o = acc_reg;
    assign r_o   = r_reg;
    assign g_o   = g_reg;

endmodule

`default_nettype wire

// File: rtl/lrmp_ctrl.sv
// Sequencer: handshakes, table build, square-and-multiply schedule for the
// cell chain, final dot product and output register. Depends on lrmp_pkg.
`default_nettype none

module lrmp_ctrl #(
    parameter int ORDER = lrmp_pkg::ORDER_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [lrmp_pkg::N_W-1:0]             s_target_count,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [lrmp_pkg::W-1:0]               m_ways_doubled,
    input  wire  [ORDER-1:0]                     allowed,
    input  wire  [ORDER-1:0][lrmp_pkg::W-1:0]    r_all,
    input  wire  [ORDER-1:0][lrmp_pkg::W-1:0]    g_all,
    input  wire  [lrmp_pkg::W-1:0]               top_acc,
    output lrmp_pkg::cell_ctrl_t                 ctrl
);

    localparam int W   = lrmp_pkg::W;
    localparam int N_W = lrmp_pkg::N_W;
    localparam int IW  = $clog2(ORDER);
    localparam int SW  = $clog2(ORDER + 1);
    localparam int BW  = $clog2(N_W);
    localparam int MW  = $clog2(lrmp_pkg::MUL_STEPS);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_TBL       = 15'b000000000000010,
        S_INIT      = 15'b000000000000100,
        S_SQ_LOAD   = 15'b000000000001000,
        S_SQ_MUL    = 15'b000000000010000,
        S_SQ_STEP   = 15'b000000000100000,
        S_SQ_END    = 15'b000000001000000,
        S_X_LOAD    = 15'b000000010000000,
        S_X_STEP    = 15'b000000100000000,
        S_X_END     = 15'b000001000000000,
        S_DOT_LOAD  = 15'b000010000000000,
        S_DOT_MUL   = 15'b000100000000000,
        S_DOT_PLACE = 15'b001000000000000,
        S_DOT_SHIFT = 15'b010000000000000,
        S_OUT       = 15'b100000000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [IW-1:0]  t_reg, t_next;
    logic [MW-1:0]  mcnt_reg, mcnt_next;
    logic [IW-1:0]  j_reg, j_next;
    logic [SW-1:0]  s_reg, s_next;
    logic           m_valid_reg, m_valid_next;
    logic [N_W-1:0] e_reg, e_next;
    logic [W-1:0]   dp_reg, dp_next;
    logic [W-1:0]   total_reg, total_next;
    logic [W-1:0]   m_data_reg, m_data_next;

    // table build term: f(j+1) += f(j+1-s) for each allowed s, with f(0) = 1
    logic [SW-1:0]  j_plus1;
    logic [IW-1:0]  s_idx;
    logic [IW-1:0]  g_idx;
    logic           in_range;
    logic           is_base;
    logic [W-1:0]   term;
    logic [W-1:0]   dp_sum;

    always_comb begin
        j_plus1  = SW'(j_reg) + SW'(1);
        s_idx    = IW'(s_reg - SW'(1));
        g_idx    = j_reg - IW'(s_reg);
        in_range = (s_reg <= j_plus1);
        is_base  = (s_reg == j_plus1);
        term     = (in_range && allowed[s_idx]) ? (is_base ? W'(1) : g_all[g_idx]) : '0;
        dp_sum   = lrmp_pkg::mod_add(dp_reg, term);
    end

    always_comb begin
        state_next   = state_reg;
        bit_next     = bit_reg;
        t_next       = t_reg;
        mcnt_next    = mcnt_reg;
        j_next       = j_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        dp_next      = dp_reg;
        total_next   = total_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        ctrl.op     = lrmp_pkg::OP_NOP;
        ctrl.g_we   = 1'b0;
        ctrl.g_idx  = lrmp_pkg::IDX_W'(j_reg);
        ctrl.g_data = dp_sum;
        ctrl.bcast  = r_all[t_reg];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    e_next = s_target_count - N_W'(1);
                    if (s_target_count == '0) begin
                        total_next = '0;
                        state_next = S_OUT;
                    end else begin
                        j_next     = '0;
                        s_next     = SW'(1);
                        dp_next    = '0;
                        state_next = S_TBL;
                    end
                end
            end
            S_TBL: begin
                if (s_reg == SW'(ORDER)) begin
                    ctrl.g_we = 1'b1;
                    dp_next   = '0;
                    s_next    = SW'(1);
                    if (j_reg == IW'(ORDER - 1)) state_next = S_INIT;
                    else j_next = j_reg + IW'(1);
                end else begin
                    dp_next = dp_sum;
                    s_next  = s_reg + SW'(1);
                end
            end
            S_INIT: begin
                ctrl.op    = lrmp_pkg::OP_R_INIT;
                bit_next   = BW'(N_W - 1);
                t_next     = IW'(ORDER - 1);
                state_next = S_SQ_LOAD;
            end
            S_SQ_LOAD: begin
                ctrl.op    = lrmp_pkg::OP_LOAD_BCAST;
                mcnt_next  = '0;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                ctrl.op   = lrmp_pkg::OP_MUL;
                mcnt_next = mcnt_reg + MW'(1);
                if (mcnt_reg == MW'(lrmp_pkg::MUL_STEPS - 1)) state_next = S_SQ_STEP;
            end
            S_SQ_STEP: begin
                ctrl.op = lrmp_pkg::OP_STEP_SQ;
                if (t_reg == '0) begin
                    state_next = S_SQ_END;
                end else begin
                    t_next     = t_reg - IW'(1);
                    state_next = S_SQ_LOAD;
                end
            end
            S_SQ_END: begin
                ctrl.op = lrmp_pkg::OP_R_FROM_ACC;
                if (e_reg[bit_reg]) begin
                    state_next = S_X_LOAD;
                end else if (bit_reg == '0) begin
                    state_next = S_DOT_LOAD;
                end else begin
                    bit_next   = bit_reg - BW'(1);
                    t_next     = IW'(ORDER - 1);
                    state_next = S_SQ_LOAD;
                end
            end
            S_X_LOAD: begin
                ctrl.op    = lrmp_pkg::OP_ACC_FROM_R;
                state_next = S_X_STEP;
            end
            S_X_STEP: begin
                ctrl.op    = lrmp_pkg::OP_STEP_X;
                state_next = S_X_END;
            end
            S_X_END: begin
                ctrl.op = lrmp_pkg::OP_R_FROM_ACC;
                if (bit_reg == '0) begin
                    state_next = S_DOT_LOAD;
                end else begin
                    bit_next   = bit_reg - BW'(1);
                    t_next     = IW'(ORDER - 1);
                    state_next = S_SQ_LOAD;
                end
            end
            S_DOT_LOAD: begin
                ctrl.op    = lrmp_pkg::OP_LOAD_OWN;
                mcnt_next  = '0;
                state_next = S_DOT_MUL;
            end
            S_DOT_MUL: begin
                ctrl.op   = lrmp_pkg::OP_MUL;
                mcnt_next = mcnt_reg + MW'(1);
                if (mcnt_reg == MW'(lrmp_pkg::MUL_STEPS - 1)) state_next = S_DOT_PLACE;
            end
            S_DOT_PLACE: begin
                ctrl.op    = lrmp_pkg::OP_PLACE;
                total_next = '0;
                t_next     = '0;
                state_next = S_DOT_SHIFT;
            end
            S_DOT_SHIFT: begin
                // products leave through the top cell one per cycle
                ctrl.op    = lrmp_pkg::OP_SHIFT;
                total_next = lrmp_pkg::mod_add(total_reg, top_acc);
                if (t_reg == IW'(ORDER - 1)) state_next = S_OUT;
                else t_next = t_reg + IW'(1);
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = lrmp_pkg::mod_add(total_reg, total_reg);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bit_reg     <= '0;
            t_reg       <= '0;
            mcnt_reg    <= '0;
            j_reg       <= '0;
            s_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            t_reg       <= t_next;
            mcnt_reg    <= mcnt_next;
            j_reg       <= j_next;
            s_reg       <= s_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg      <= e_next;
        dp_reg     <= dp_next;
        total_reg  <= total_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_ways_doubled = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/linear_recurrence_mod_power_unit.sv
// Top level of the step-sequence counter: mask register, chain of
// coefficient cells and sequencer. Depends on lrmp_pkg, lrmp_cell, lrmp_ctrl.
//
// Returns 2*f(n) mod 1000000007 for each target count n, where f(n) counts
// ordered sums of allowed step sizes. x^(n-1) is reduced modulo the
// recurrence's characteristic polynomial by square-and-multiply over all
// 60 exponent bits, one coefficient per cell; the result is its dot product
// with the step table. One transaction at a time; the schedule is paced by
// the per-cell modular multiplier that retires two bits a cycle. n = 0
// skips the computation and goes straight to the output stage. A finished
// result waits in the output register while the next count is taken.
// step_mask must be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module linear_recurrence_mod_power_unit #(
    parameter int ORDER = lrmp_pkg::ORDER_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire  [lrmp_pkg::MASK_W-1:0]  cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [lrmp_pkg::N_W-1:0]     s_target_count,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [lrmp_pkg::W-1:0]       m_ways_doubled
);

    localparam int W    = lrmp_pkg::W;
    localparam int PADW = (ORDER > lrmp_pkg::MASK_W) ? ORDER : lrmp_pkg::MASK_W;

    logic [lrmp_pkg::MASK_W-1:0] step_mask_reg, step_mask_next;
    logic [PADW-1:0]             mask_pad;
    logic [ORDER-1:0]            allowed;

    assign step_mask_next = cfg_we ? cfg_wdata : step_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) step_mask_reg <= '0;
        else          step_mask_reg <= step_mask_next;
    end

    // sizes above the register width are never allowed
    assign mask_pad = PADW'(step_mask_reg);
    assign allowed  = mask_pad[ORDER-1:0];

    lrmp_pkg::cell_ctrl_t        cell_ctrl;
    logic [ORDER-1:0][W-1:0]     acc_all;
    logic [ORDER-1:0][W-1:0]     r_all;
    logic [ORDER-1:0][W-1:0]     g_all;
    logic [ORDER-1:0][W-1:0]     left_acc;

    for (genvar k = 0; k < ORDER; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign left_acc[k] = '0;
        end else begin : g_rest
            assign left_acc[k] = acc_all[k-1];
        end

        // x^ORDER folds back onto x^k when step ORDER-k is allowed
        lrmp_cell #(
            .INDEX (k)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .left_acc (left_acc[k]),
            .fb_val   (acc_all[ORDER-1]),
            .fb_en    (allowed[ORDER-1-k]),
            .acc_o    (acc_all[k]),
            .r_o      (r_all[k]),
            .g_o      (g_all[k])
        );
    end

    lrmp_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_count (s_target_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ways_doubled (m_ways_doubled),
        .allowed        (allowed),
        .r_all          (r_all),
        .g_all          (g_all),
        .top_acc        (acc_all[ORDER-1]),
        .ctrl           (cell_ctrl)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after a transaction was taken");

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_ways_doubled < lrmp_pkg::P_MOD))
        else $error("result not reduced modulo p");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a transaction in progress");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for linear_recurrence_mod_power_unit: directed rows, then random counts
// under several step masks, each result compared with a typed value or a behavioral step-sequence counter.
// Depends on lrmp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

    localparam int W      = lrmp_pkg::W;
    localparam int MASK_W = lrmp_pkg::MASK_W;
    localparam int N_W    = lrmp_pkg::N_W;
    localparam longint unsigned PRIME = 64'd1000000007;
    localparam int ORD = lrmp_pkg::ORDER_DEF;
    localparam logic [N_W-1:0] N_MAX = {N_W{1'b1}};

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic [N_W-1:0]    count;
        bit                typed;
        logic [W-1:0]      ways;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [MASK_W-1:0]   cfg_wdata = '0;
    logic                s_valid = 1'b0;
    wire                 s_ready;
    logic [N_W-1:0]      s_target_count = '0;
    wire                 m_valid;
    logic                m_ready = 1'b0;
    wire  [W-1:0]        m_ways_doubled;

    logic [MASK_W-1:0]   mask_model = '0;   // mirror of the step mask register
    logic [W-1:0]        ways_pending[$];
    bit                  calm = 1'b0;       // no idling on either side
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  masks_used = 0;
    stim_row_t           stim_rows[$];
    logic [W-1:0]        typed_ways[$];

    linear_recurrence_mod_power_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_count (s_target_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ways_doubled (m_ways_doubled)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", ways_pending.size());
        $display("FAIL");
        $finish;
    end

    function automatic longint unsigned mac(longint unsigned acc, longint unsigned a,
                                            longint unsigned b);
        return (acc + (a * b) % PRIME) % PRIME;
    endfunction

    // 2 * (number of ordered step sequences summing to n) mod p
    function automatic logic [W-1:0] count_ways_doubled(logic [MASK_W-1:0] mask,
                                                        logic [N_W-1:0] n);
        longint unsigned ways_tbl[ORD];
        longint unsigned cm[ORD][ORD];
        longint unsigned sq[ORD][ORD];
        longint unsigned row[ORD];
        longint unsigned row_nxt[ORD];
        longint unsigned acc;
        longint unsigned f;
        logic [N_W-1:0]  e;
        f = 0;
        for (int i = 0; i < ORD; i++) begin
            ways_tbl[i] = 0;
            for (int s = 1; s <= i + 1; s++) begin
                if (mask[s-1]) begin
                    if (s == i + 1) ways_tbl[i] = (ways_tbl[i] + 1) % PRIME;
                    else ways_tbl[i] = (ways_tbl[i] + ways_tbl[i-s]) % PRIME;
                end
            end
        end
        if (n == 0) begin
            f = 0;
        end else if (n <= ORD) begin
            f = ways_tbl[n-1];
        end else begin
            e = n - ORD;
            for (int i = 0; i < ORD; i++) begin
                row[i] = 0;
                for (int j = 0; j < ORD; j++) cm[i][j] = 0;
            end
            for (int i = 1; i < ORD; i++) cm[i-1][i] = 1;
            for (int s = 1; s <= ORD; s++) if (mask[s-1]) cm[ORD-1][ORD-s] = 1;
            row[ORD-1] = 1;
            forever begin
                if (e[0]) begin
                    for (int j = 0; j < ORD; j++) begin
                        acc = 0;
                        for (int k = 0; k < ORD; k++) acc = mac(acc, row[k], cm[k][j]);
                        row_nxt[j] = acc;
                    end
                    row = row_nxt;
                end
                e = e >> 1;
                if (e == 0) break;
                for (int i = 0; i < ORD; i++)
                    for (int j = 0; j < ORD; j++) begin
                        acc = 0;
                        for (int k = 0; k < ORD; k++) acc = mac(acc, cm[i][k], cm[k][j]);
                        sq[i][j] = acc;
                    end
                cm = sq;
            end
            for (int i = 0; i < ORD; i++) f = mac(f, row[i], ways_tbl[i]);
        end
        return W'((f * 2) % PRIME);
    endfunction

    // predictor: one expectation per accepted transaction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (typed_ways.size() != 0) ways_pending.push_back(typed_ways.pop_front());
            else ways_pending.push_back(count_ways_doubled(mask_model, s_target_count));
        end
    end

    // result checker
    always @(posedge aclk) begin
        logic [W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (ways_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", m_ways_doubled);
            end else begin
                want = ways_pending.pop_front();
                if (want !== m_ways_doubled) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ways_doubled mismatch: expected %0d, got %0d",
                                 want, m_ways_doubled);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 8);
    end

    task automatic write_mask(logic [MASK_W-1:0] value);
        // first let the predictor queue the last accepted transaction
        @(posedge aclk);
        while (ways_pending.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        mask_model  = value;
        masks_used++;
    endtask

    // holds valid until the transaction is taken
    task automatic send_count(logic [N_W-1:0] n, bit typed, logic [W-1:0] ways);
        while (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        if (typed) typed_ways.push_back(ways);
        s_valid        <= 1'b1;
        s_target_count <= n;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    function automatic logic [N_W-1:0] rand_count();
        logic [N_W-1:0] n;
        case ($urandom_range(5))
            0: n = N_W'($urandom_range(2 * ORD));
            1: n = N_W'(ORD - 1 + $urandom_range(2));
            2: n = N_MAX - N_W'($urandom_range(3));
            3: n = N_W'($urandom_range(100000));
            default: n = N_W'({$urandom, $urandom});
        endcase
        return n;
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        case ($urandom_range(4))
            0: return '1;
            1: return MASK_W'(1) << $urandom_range(MASK_W - 1);
            default: return MASK_W'($urandom);
        endcase
    endfunction

    function automatic stim_row_t row(logic [MASK_W-1:0] mask, logic [N_W-1:0] n,
                                      bit typed = 0, logic [W-1:0] ways = '0);
        stim_row_t r;
        r.mask = mask; r.count = n; r.typed = typed; r.ways = ways;
        return r;
    endfunction

    initial begin
        logic [MASK_W-1:0] cur_mask;
        // empty mask after reset: nothing is reachable
        stim_rows.push_back(row('0, 0, 1, 0));
        stim_rows.push_back(row('0, 1, 1, 0));
        stim_rows.push_back(row('0, N_MAX, 1, 0));
        // single unit step: exactly one sequence for every nonzero count
        stim_rows.push_back(row(15'h0001, 0, 1, 0));
        stim_rows.push_back(row(15'h0001, 1, 1, 2));
        stim_rows.push_back(row(15'h0001, 16, 1, 2));
        stim_rows.push_back(row(15'h0001, N_MAX, 1, 2));
        // only step 2: odd counts unreachable
        stim_rows.push_back(row(15'h0002, 7, 1, 0));
        stim_rows.push_back(row(15'h0002, 8, 1, 2));
        stim_rows.push_back(row(15'h0002, 61, 1, 0));
        stim_rows.push_back(row(15'h0002, N_MAX - 1, 1, 2));
        // every step allowed
        stim_rows.push_back(row(15'h7fff, 0, 1, 0));
        stim_rows.push_back(row(15'h7fff, 1, 1, 2));
        stim_rows.push_back(row(15'h7fff, 2, 1, 4));
        stim_rows.push_back(row(15'h7fff, 15));
        stim_rows.push_back(row(15'h7fff, 16));
        stim_rows.push_back(row(15'h7fff, N_MAX));
        stim_rows.push_back(row(15'h7fff, 60'h555_5555_5555_5555));
        // only the largest step
        stim_rows.push_back(row(15'h4000, 15, 1, 2));
        stim_rows.push_back(row(15'h4000, 14, 1, 0));
        stim_rows.push_back(row(15'h4000, 30));
        stim_rows.push_back(row(15'h4000, 60'haaa_aaaa_aaaa_aaaa));
        stim_rows.push_back(row(15'h2a55, 1000));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cur_mask = '0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].mask != cur_mask) begin
                s_valid <= 1'b0;
                write_mask(stim_rows[i].mask);
                cur_mask = stim_rows[i].mask;
            end
            send_count(stim_rows[i].count, stim_rows[i].typed, stim_rows[i].ways);
        end

        for (int phase = 0; phase < 5; phase++) begin
            s_valid <= 1'b0;
            write_mask(phase == 0 ? 15'h7fff : phase == 4 ? 15'h0000 : rand_mask());
            for (int k = 0; k < 16; k++) begin
                calm = (phase == 2);
                send_count(rand_count(), 0, '0);
            end
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (ways_pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("checked %0d results over %0d step masks, %0d mismatches",
                 results_seen, masks_used, mismatches);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
